/* sv/rslm_pkg.sv */
`default_nettype none
// ============================================================================
// rslm_pkg
// Shared types and fixed constants of the linear resampler with soft limiter.
// ============================================================================
package rslm_pkg;

    // Sample and frame formats
    localparam int SAMPLE_W = 16;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_t;

    // Configuration port
    localparam int STEP_W     = 19;
    localparam int GAIN_W     = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 1'd1;

    localparam logic [STEP_W-1:0] STEP_RESET = 19'd60211;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 15'd24576;

    // Gain is Q1.14
    localparam int GAIN_FRAC_W = 14;

    // Results per source frame
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Soft-knee limiter
    localparam int FULL_LEVEL_INT = 32767;
    localparam int KNEE_LEVEL_INT = 24000;
    localparam int MAG_W          = 16;
    localparam int OVER_W         = 15;
    localparam int HEAD_W         = 14;

    localparam logic [MAG_W-1:0]  KNEE_LEVEL = MAG_W'(KNEE_LEVEL_INT);
    localparam logic [HEAD_W-1:0] HEAD_ROOM  = HEAD_W'(FULL_LEVEL_INT - KNEE_LEVEL_INT);

    // Knee divider: quotient below HEAD_ROOM, numerator HEAD_ROOM * over
    localparam int DIV_N_W           = 28;
    localparam int DIV_D_W           = 16;
    localparam int DIV_Q_W           = 14;
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = DIV_Q_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

endpackage
`default_nettype wire

/* sv/rslm_queue.sv */
`default_nettype none
// ============================================================================
// rslm_queue
// Short register FIFO carrying interpolation jobs from front to back.
// ============================================================================
module rslm_queue #(
    parameter int WIDTH = 49
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);
    import rslm_pkg::*;

    // Depth is a power of two so the pointers wrap on their own
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;

    assign full     = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* sv/rslm_front.sv */
`default_nettype none
// ============================================================================
// rslm_front
// Accept source frames, track the read position and issue one job per
// output frame into the job queue.
// ============================================================================
module rslm_front #(
    parameter int FRAC_W = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire rslm_pkg::sample_t             left_in,
    input  wire rslm_pkg::sample_t             right_in,
    input  wire logic                          restart,
    input  wire logic [rslm_pkg::STEP_W-1:0]   step,
    input  wire logic                          q_full,
    output logic                               push,
    output rslm_pkg::frame_t                   job_held,
    output rslm_pkg::frame_t                   job_new,
    output logic      [FRAC_W-1:0]             job_pos,
    output logic                               job_last
);
    import rslm_pkg::*;

    localparam int POS_W = ((FRAC_W > STEP_W) ? FRAC_W : STEP_W) + 1;
    localparam logic [POS_W-1:0]     ONE_POS  = POS_W'(1) << FRAC_W;
    localparam logic [POS_W-1:0]     MIN_STEP = ONE_POS >> 3;
    localparam logic [RES_CNT_W-1:0] CNT_LAST = RES_CNT_W'(MAX_RESULTS - 1);

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } fstate_t;

    fstate_t              st_reg, st_next;
    frame_t               held_reg, held_next;
    logic                 held_valid_reg, held_valid_next;
    frame_t               new_reg, new_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;

    logic             in_accept;
    frame_t           frame_in;
    logic [POS_W-1:0] step_eff;
    logic [POS_W-1:0] pos_start;
    logic             held_start;
    logic [POS_W-1:0] pos_sum;
    logic             is_last;

    assign in_stall  = (st_reg != F_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign frame_in  = '{left: left_in, right: right_in};

    // Raise a tiny step so one frame never yields more than eight outputs
    assign step_eff   = (POS_W'(step) < MIN_STEP) ? MIN_STEP : POS_W'(step);
    assign pos_start  = restart ? '0 : pos_reg;
    assign held_start = !restart && held_valid_reg;
    assign pos_sum    = pos_reg + step_eff;
    assign is_last    = (pos_sum >= ONE_POS) || (cnt_reg == CNT_LAST);

    assign push     = (st_reg == F_EMIT) && !q_full;
    assign job_held = held_reg;
    assign job_new  = new_reg;
    assign job_pos  = pos_reg[FRAC_W-1:0];
    assign job_last = is_last;

    always_comb
    begin
        st_next         = st_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        new_next        = new_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (in_accept)
                begin
                    if (!held_start)
                    begin
                        // first frame after reset or restart: store only
                        held_next       = frame_in;
                        held_valid_next = 1'b1;
                        pos_next        = pos_start;
                    end
                    else if (pos_start >= ONE_POS)
                    begin
                        // step above one frame: skip this frame
                        pos_next  = pos_start - ONE_POS;
                        held_next = frame_in;
                    end
                    else
                    begin
                        new_next = frame_in;
                        pos_next = pos_start;
                        cnt_next = '0;
                        st_next  = F_EMIT;
                    end
                end
            end
            F_EMIT:
            begin
                if (push)
                begin
                    if (is_last)
                    begin
                        pos_next  = pos_sum - ONE_POS;
                        held_next = new_reg;
                        st_next   = F_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_sum;
                        cnt_next = cnt_reg + RES_CNT_W'(1);
                    end
                end
            end
            default:
            begin
                st_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= F_IDLE;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            new_reg        <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            st_reg         <= st_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            new_reg        <= new_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* sv/rslm_div.sv */
`default_nettype none
// ============================================================================
// rslm_div
// Restoring divider for the limiter knee, two quotient bits per cycle.
// ============================================================================
module rslm_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [rslm_pkg::DIV_N_W-1:0]   num,
    input  wire logic [rslm_pkg::DIV_D_W-1:0]   den,
    output logic                                done,
    output logic      [rslm_pkg::DIV_Q_W-1:0]   quo
);
    import rslm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   lo_reg, lo_next;
    logic [DIV_Q_W-1:0]   q_reg, q_next;
    logic [DIV_D_W-1:0]   den_reg, den_next;

    assign done = done_reg;
    assign quo  = q_reg;

    always_comb
    begin
        logic [DIV_D_W:0]   trial;
        logic [DIV_D_W-1:0] rem_c;
        logic [DIV_Q_W-1:0] lo_c;
        logic [DIV_Q_W-1:0] q_c;
        logic               qbit;

        rem_c = rem_reg;
        lo_c  = lo_reg;
        q_c   = q_reg;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++)
        begin
            trial = {rem_c, lo_c[DIV_Q_W-1]};
            qbit  = (trial >= {1'b0, den_reg});
            if (qbit)
            begin
                rem_c = DIV_D_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_c = trial[DIV_D_W-1:0];
            end
            lo_c = {lo_c[DIV_Q_W-2:0], 1'b0};
            q_c  = {q_c[DIV_Q_W-2:0], qbit};
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            // quotient fits DIV_Q_W bits, so the top bits start below den
            rem_next  = DIV_D_W'(num[DIV_N_W-1:DIV_Q_W]);
            lo_next   = num[DIV_Q_W-1:0];
            q_next    = '0;
            den_next  = den;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = rem_c;
            lo_next  = lo_c;
            q_next   = q_c;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

endmodule
`default_nettype wire

/* sv/rslm_back.sv */
`default_nettype none
// ============================================================================
// rslm_back
// Carry out one job at a time: interpolate, apply gain, soft-limit both
// channels and hand the frame to the output register.
// ============================================================================
module rslm_back #(
    parameter int FRAC_W = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    output logic                               pop,
    input  wire rslm_pkg::frame_t              job_held,
    input  wire rslm_pkg::frame_t              job_new,
    input  wire logic [FRAC_W-1:0]             job_pos,
    input  wire logic                          job_last,
    input  wire logic [rslm_pkg::GAIN_W-1:0]   gain,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output rslm_pkg::sample_t                  left_out,
    output rslm_pkg::sample_t                  right_out,
    output logic                               last
);
    import rslm_pkg::*;

    localparam int PROD_W = FRAC_W + SAMPLE_W + 2;
    localparam int SC_W   = 2 * SAMPLE_W - GAIN_FRAC_W;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_INTERP,
        B_GAIN,
        B_LIM,
        B_KNEE,
        B_DIV,
        B_OUT
    } bstate_t;

    bstate_t                    st_reg, st_next;
    logic                       ch_reg, ch_next;
    logic                       out_valid_reg, out_valid_next;
    frame_t                     held_reg, held_next;
    frame_t                     new_reg, new_next;
    logic [FRAC_W-1:0]          pos_reg, pos_next;
    logic                       last_reg, last_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    sample_t                    v_reg, v_next;
    logic signed [2*SAMPLE_W-1:0] gp_reg, gp_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic [OVER_W-1:0]          over_reg, over_next;
    sample_t                    res_l_reg, res_l_next;
    sample_t                    res_r_reg, res_r_next;
    sample_t                    left_out_reg, left_out_next;
    sample_t                    right_out_reg, right_out_next;
    logic                       last_out_reg, last_out_next;

    sample_t                    a_c, b_c;
    logic signed [SAMPLE_W:0]   diff_c;
    logic signed [PROD_W-1:0]   prod_c;
    logic [PROD_W-1:0]          num_c;
    logic [PROD_W-FRAC_W-1:0]   interp_c;
    logic signed [2*SAMPLE_W-1:0] gp_c;
    logic [SC_W-1:0]            sc_c;
    logic [SC_W-1:0]            mag_full_c;
    logic [MAG_W-1:0]           mag_c;
    logic [MAG_W-1:0]           comp_c;
    sample_t                    res_c;
    logic                       res_done;
    logic                       out_load;

    logic                       div_start;
    logic [DIV_N_W-1:0]         div_num;
    logic [DIV_D_W-1:0]         div_den;
    logic                       div_done;
    logic [DIV_Q_W-1:0]         div_quo;

    rslm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign pop       = (st_reg == B_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign last      = last_out_reg;

    // Channel operands
    assign a_c    = ch_reg ? held_reg.right : held_reg.left;
    assign b_c    = ch_reg ? new_reg.right  : new_reg.left;
    assign diff_c = {b_c[SAMPLE_W-1], b_c} - {a_c[SAMPLE_W-1], a_c};
    assign prod_c = diff_c * $signed({1'b0, pos_reg});

    // a * 2^F + (b - a) * pos, shifted down with truncation toward zero
    assign num_c    = {{2{a_c[SAMPLE_W-1]}}, a_c, {FRAC_W{1'b0}}} + prod_reg;
    assign interp_c = num_c[PROD_W-1:FRAC_W]
                    + (PROD_W-FRAC_W)'(num_c[PROD_W-1] && (num_c[FRAC_W-1:0] != '0));

    assign gp_c = v_reg * $signed({1'b0, gain});

    // Gain product back to Q0, truncated toward zero
    assign sc_c = gp_reg[2*SAMPLE_W-1:GAIN_FRAC_W]
                + SC_W'(gp_reg[2*SAMPLE_W-1] && (gp_reg[GAIN_FRAC_W-1:0] != '0));
    assign mag_full_c = sc_c[SC_W-1] ? (~sc_c + SC_W'(1)) : sc_c;
    assign mag_c      = mag_full_c[MAG_W-1:0];

    assign div_num = DIV_N_W'(HEAD_ROOM) * DIV_N_W'(over_reg);
    assign div_den = DIV_D_W'(over_reg) + DIV_D_W'(HEAD_ROOM);
    assign comp_c  = KNEE_LEVEL + MAG_W'(div_quo);

    assign out_load = (st_reg == B_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        st_next        = st_reg;
        ch_next        = ch_reg;
        held_next      = held_reg;
        new_next       = new_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        v_next         = v_reg;
        gp_next        = gp_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        over_next      = over_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        last_out_next  = last_out_reg;
        res_c          = '0;
        res_done       = 1'b0;
        div_start      = 1'b0;

        case (st_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    held_next = job_held;
                    new_next  = job_new;
                    pos_next  = job_pos;
                    last_next = job_last;
                    ch_next   = 1'b0;
                    st_next   = B_MUL;
                end
            end
            B_MUL:
            begin
                prod_next = prod_c;
                st_next   = B_INTERP;
            end
            B_INTERP:
            begin
                v_next  = interp_c[SAMPLE_W-1:0];
                st_next = B_GAIN;
            end
            B_GAIN:
            begin
                gp_next = gp_c;
                st_next = B_LIM;
            end
            B_LIM:
            begin
                mag_next  = mag_c;
                neg_next  = sc_c[SC_W-1];
                over_next = OVER_W'(mag_c - KNEE_LEVEL);
                st_next   = B_KNEE;
            end
            B_KNEE:
            begin
                if (mag_reg <= KNEE_LEVEL)
                begin
                    res_c    = neg_reg ? sample_t'(~mag_reg + MAG_W'(1)) : sample_t'(mag_reg);
                    res_done = 1'b1;
                end
                else
                begin
                    div_start = 1'b1;
                    st_next   = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    res_c    = neg_reg ? sample_t'(~comp_c + MAG_W'(1)) : sample_t'(comp_c);
                    res_done = 1'b1;
                end
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    left_out_next  = res_l_reg;
                    right_out_next = res_r_reg;
                    last_out_next  = last_reg;
                    st_next        = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase

        // Store a finished channel and move to the next one
        if (res_done)
        begin
            if (!ch_reg)
            begin
                res_l_next = res_c;
                ch_next    = 1'b1;
                st_next    = B_MUL;
            end
            else
            begin
                res_r_next = res_c;
                st_next    = B_OUT;
            end
        end

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        new_reg       <= new_next;
        pos_reg       <= pos_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        v_reg         <= v_next;
        gp_reg        <= gp_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        over_reg      <= over_next;
        res_l_reg     <= res_l_next;
        res_r_reg     <= res_r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        last_out_reg  <= last_out_next;
    end

endmodule
`default_nettype wire

/* sv/linear_resampler_soft_limiter_core.sv */
`default_nettype none
// ============================================================================
// linear_resampler_soft_limiter_core
// Stereo linear-interpolation rate converter with gain and soft-knee limiter.
// ============================================================================
// Usage:
//   Source frames enter on in_valid/in_stall (left_in, right_in, restart).
//   Each frame yields zero to eight output frames on out_valid/out_stall;
//   last marks the final output frame of a source frame. The first frame
//   after reset or restart only primes the held frame and yields nothing.
//   step_ratio (index 0) and gain (index 1) are written on cfg_valid/
//   cfg_ready; cfg_ready is always high. Write them only while idle.
// Timing:
//   The front takes a frame and queues one job per output frame, one job a
//   cycle while the queue has room, and stalls its input until its jobs are
//   queued. The back works one job at a time: pop, then per channel the
//   multiply, interpolate, gain, limit and knee states, plus the shared knee
//   divider when the level is above the knee, then the output register.
// Reset and stall:
//   Reset clears the held frame, read position, queue and output valid and
//   loads the default step (44.1 to 48 kHz) and unity gain. A stalled output
//   holds its frame; the back finishes the next frame meanwhile, then waits,
//   and the queue fills until the front stalls its input.
// ============================================================================
module linear_resampler_soft_limiter_core #(
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // source frames
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire rslm_pkg::sample_t                 left_in,
    input  wire rslm_pkg::sample_t                 right_in,
    input  wire logic                              restart,
    // output frames
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output rslm_pkg::sample_t                      left_out,
    output rslm_pkg::sample_t                      right_out,
    output logic                                   last,
    // register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rslm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rslm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rslm_pkg::*;

    localparam int FRAC_W = POSITION_FRACTION_BITS;
    // job: held frame, new frame, position fraction, last flag
    localparam int JOB_W  = 2 * $bits(frame_t) + FRAC_W + 1;

    logic [STEP_W-1:0] step_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_eff;

    logic              push;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    frame_t            f_held, f_new;
    logic [FRAC_W-1:0] f_pos;
    logic              f_last;
    logic [JOB_W-1:0]  push_data;
    logic [JOB_W-1:0]  pop_data;
    frame_t            b_held, b_new;
    logic [FRAC_W-1:0] b_pos;
    logic              b_last;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEP_RATIO:
                begin
                    step_reg <= cfg_data[STEP_W-1:0];
                end
                REG_GAIN:
                begin
                    gain_reg <= cfg_data[GAIN_W-1:0];
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // Saturate the gain at 1.5
    assign gain_eff = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;

    // Front: frame intake, position tracking, job issue
    rslm_front #(
        .FRAC_W (FRAC_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .left_in  (left_in),
        .right_in (right_in),
        .restart  (restart),
        .step     (step_reg),
        .q_full   (q_full),
        .push     (push),
        .job_held (f_held),
        .job_new  (f_new),
        .job_pos  (f_pos),
        .job_last (f_last)
    );

    assign push_data = {f_held, f_new, f_pos, f_last};

    // Job queue decouples front and back
    rslm_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign {b_held, b_new, b_pos, b_last} = pop_data;

    // Back: arithmetic, limiter and output register
    rslm_back #(
        .FRAC_W (FRAC_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (pop),
        .job_held  (b_held),
        .job_new   (b_new),
        .job_pos   (b_pos),
        .job_last  (b_last),
        .gain      (gain_eff),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .last      (last)
    );

endmodule
`default_nettype wire
